FILE: sv/wve_pkg.sv
// Shared types and constants for the windowed velocity estimator.
// No dependencies.
`timescale 1ns / 1ps
package wve_pkg;

  typedef enum logic [1:0] {
    CMD_POS  = 2'd0,
    CMD_IDLE = 2'd1,
    CMD_CALC = 2'd2,
    CMD_RST  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_ZERO_DT  = 2'd2,
    ST_NOT_CALC = 2'd3
  } status_t;

  typedef enum logic {
    REG_AGE_LIMIT = 1'b0,
    REG_MIN_SAMP  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] position;
    logic [31:0]        time_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] tracked_position;
    logic signed [31:0] velocity;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SUM,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

FILE: sv/windowed_velocity_estimator_core.sv
// Top level: config registers, front queue and back end.
// Depends on wve_pkg, wve_front, wve_back.
//
//  port group | dir | handshake            | word
//  in_*       | in  | in_valid/in_ready    | in_word_t (cmd, position, time_ms)
//  out_*      | out | out_valid/out_ready  | out_word_t (tracked_position, velocity, status)
//  cfg_*      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Update, idle tick and reset words pass the front queue and are answered from the
// back end's output register. Calculate with enough samples walks the ring (n
// samples after the append, at most RING_DEPTH), runs the bit-serial divider (skipped
// when the summed time is zero) and presents the word; the single-read ring port
// makes the walk read one sample at a time.
// Reset is synchronous; the ring contents are not cleared, only its pointers.
// A stalled output holds the back end; the front queue keeps taking up to two words.
`timescale 1ns / 1ps
module windowed_velocity_estimator_core
  import wve_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] age_r;
  logic [4:0]  min_r;
  logic        qv, qr;
  in_word_t    qd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= 16'd100;
      min_r <= 5'd2;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_AGE_LIMIT: age_r <= cfg_data;
        REG_MIN_SAMP:  min_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  wve_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  wve_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_ready(qr), .q_data(qd),
    .age_limit(age_r), .min_samples(min_r),
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: sv/wve_front.sv
// Front end: accepts input words into a two-entry queue.
// Depends on wve_pkg.
`timescale 1ns / 1ps
module wve_front
  import wve_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_word_t q_data
);

  in_word_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");

endmodule

FILE: sv/wve_back.sv
// Back end: ring of samples, windowed sum walk and serial divider.
// Depends on wve_pkg.
`timescale 1ns / 1ps
module wve_back
  import wve_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  in_word_t    q_data,
  input  logic [15:0] age_limit,
  input  logic [4:0]  min_samples,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int DIST_W = 33 + $clog2(RING_DEPTH);
  localparam int TOT_W  = DIST_W;
  localparam logic [IW-1:0] LAST = IW'(RING_DEPTH - 1);

  logic [31:0] mov_mem [RING_DEPTH];
  logic [31:0] tim_mem [RING_DEPTH];

  bk_state_t state_r, state_nxt;
  logic [IW-1:0] oldest_r, nwi_r, idx_r;
  logic          empty_r;
  logic [31:0]   pos_r;
  logic [31:0]   newest_r, prev_r, rd_mov_r, rd_tim_r;
  logic          first_r;
  logic signed [DIST_W-1:0] dist_r;
  logic signed [TOT_W-1:0]  tot_r;
  logic [DIST_W-1:0] rem_r, quo_r, dvs_r;
  logic [5:0]    bit_r;
  logic          neg_r;
  out_word_t     out_r;
  logic          ovalid_r;

  logic        wr_en;
  logic [31:0] wr_mov;
  logic [IW-1:0] nwi_inc, old_inc, idx_inc;
  logic [CW-1:0] count;
  logic [IW:0]   diff;
  logic        accept;
  logic        res_set;
  logic signed [31:0] age_d, dt;
  logic [DIST_W:0] rem_sh;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] v);
    inc = (v == LAST) ? '0 : v + 1'b1;
  endfunction

  assign nwi_inc = inc(nwi_r);
  assign old_inc = inc(oldest_r);
  assign idx_inc = inc(idx_r);
  assign diff    = {1'b0, nwi_r} - {1'b0, oldest_r};
  always_comb begin
    if (empty_r) count = '0;
    else if (nwi_r == oldest_r) count = CW'(RING_DEPTH);
    else if (diff[IW]) count = CW'(diff + (IW+1)'(RING_DEPTH));
    else count = CW'(diff);
  end

  assign q_ready = (state_r == BK_IDLE) && !(ovalid_r && !out_ready);
  assign accept  = q_valid && q_ready;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  always_comb begin
    wr_en  = 1'b0;
    wr_mov = 32'd0;
    if (accept) begin
      case (q_data.cmd)
        CMD_POS: begin
          wr_en = 1'b1;
          wr_mov = q_data.position - pos_r;
        end
        CMD_IDLE: wr_en = 1'b1;
        CMD_CALC: wr_en = (32'(min_samples) <= 32'(count));
        default: wr_en = 1'b0;
      endcase
    end
  end

  assign res_set = (accept && !(q_data.cmd == CMD_CALC && wr_en))
                   || (state_r == BK_DONE && state_nxt == BK_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mov_mem[nwi_r] <= wr_mov;
      tim_mem[nwi_r] <= q_data.time_ms;
    end
    rd_mov_r <= mov_mem[idx_r];
    rd_tim_r <= tim_mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (accept && wr_en && q_data.cmd == CMD_CALC) state_nxt = BK_READ;
      BK_READ: state_nxt = (idx_r == nwi_r && !first_r) ? BK_DIV : BK_SUM;
      BK_SUM:  state_nxt = BK_READ;
      BK_DIV:  if (tot_r == '0 || bit_r == 6'd0) state_nxt = BK_DONE;
      BK_DONE: if (!ovalid_r || out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign age_d = newest_r - rd_tim_r;
  assign dt    = rd_tim_r - prev_r;
  assign rem_sh = {rem_r, quo_r[DIST_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      oldest_r <= '0;
      nwi_r    <= '0;
      empty_r  <= 1'b1;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= res_set || (ovalid_r && !out_ready);
      if (wr_en) begin
        if (empty_r) oldest_r <= nwi_r;
        else if (oldest_r == nwi_r) oldest_r <= old_inc;
        nwi_r   <= nwi_inc;
        empty_r <= 1'b0;
      end
      if (accept) begin
        case (q_data.cmd)
          CMD_POS: pos_r <= q_data.position;
          CMD_RST: begin
            oldest_r <= '0;
            nwi_r    <= '0;
            empty_r  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: if (accept) begin
        newest_r <= q_data.time_ms;
        first_r  <= 1'b1;
        idx_r    <= empty_r ? nwi_r : ((oldest_r == nwi_r) ? old_inc : oldest_r);
        dist_r   <= '0;
        tot_r    <= '0;
        case (q_data.cmd)
          CMD_POS:  out_r <= '{q_data.position, 32'sd0, ST_NOT_CALC};
          CMD_CALC: if (!wr_en) out_r <= '{pos_r, 32'sd0, ST_FEW};
          default:  out_r <= '{pos_r, 32'sd0, ST_NOT_CALC};
        endcase
      end
      BK_READ: begin
        idx_r <= idx_inc;
        if (idx_r == nwi_r && !first_r) begin
          neg_r <= dist_r[DIST_W-1] ^ tot_r[TOT_W-1];
          quo_r <= dist_r[DIST_W-1] ? DIST_W'(-dist_r) : DIST_W'(dist_r);
          dvs_r <= tot_r[TOT_W-1] ? TOT_W'(-tot_r) : TOT_W'(tot_r);
          rem_r <= '0;
          bit_r <= 6'(DIST_W);
        end
      end
      BK_SUM: begin
        prev_r  <= rd_tim_r;
        first_r <= 1'b0;
        if (!first_r && age_d <= $signed({16'd0, age_limit})) begin
          dist_r <= dist_r + DIST_W'($signed(rd_mov_r));
          tot_r  <= tot_r + TOT_W'(dt);
        end
      end
      BK_DIV: begin
        if (tot_r == '0) begin
          out_r <= '{pos_r, 32'sd0, ST_ZERO_DT};
        end else if (bit_r != 6'd0) begin
          bit_r <= bit_r - 6'd1;
          if (rem_sh >= {1'b0, dvs_r}) begin
            rem_r <= DIST_W'(rem_sh - {1'b0, dvs_r});
            quo_r <= {quo_r[DIST_W-2:0], 1'b1};
          end else begin
            rem_r <= DIST_W'(rem_sh);
            quo_r <= {quo_r[DIST_W-2:0], 1'b0};
          end
        end else begin
          if (neg_r)
            out_r <= '{pos_r, (quo_r > DIST_W'(33'h80000000)) ? 32'sh80000000
                      : 32'(-quo_r), ST_OK};
          else
            out_r <= '{pos_r, (quo_r > DIST_W'(32'h7fffffff)) ? 32'sh7fffffff
                      : 32'(quo_r), ST_OK};
        end
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> state_r == BK_IDLE) else $error("accept while busy");
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> oldest_r == '0 || $past(empty_r) == 1'b0 || oldest_r == $past(oldest_r))
    else $error("ring pointers moved while empty");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DONE && state_nxt == BK_IDLE |=> out_valid)
    else $error("result lost");

endmodule
